// ===== hdl/assoc_legendre_evaluator_core_macros.svh =====
// Assertion macros shared by the associated Legendre evaluator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSOC_LEGENDRE_EVALUATOR_CORE_MACROS_SVH
`define ASSOC_LEGENDRE_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ALG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ALG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hdl/alg_pkg.sv =====
// Package for the associated Legendre evaluator: constants, codes, unit interfaces,
// double factorial table. No dependencies.
`timescale 1ns / 1ps

package alg_pkg;

  localparam int MAX_DEGREE    = 12;
  localparam int ARG_FRAC_BITS = 30;
  localparam int OUT_FRAC_BITS = 16;
  localparam int SEED_SH       = ARG_FRAC_BITS - OUT_FRAC_BITS;

  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 72;

  localparam logic [31:0] ARG_ONE32  = 32'd1 << ARG_FRAC_BITS;
  localparam logic [31:0] ARG_MONE32 = 32'd0 - ARG_ONE32;
  localparam logic [63:0] SQ_ONE     = 64'd1 << (2 * ARG_FRAC_BITS);
  localparam logic [63:0] VAL_MAX    = {1'b0, {63{1'b1}}};
  localparam logic [63:0] VAL_MIN    = {1'b1, {63{1'b0}}};

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ORDER = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE, S_XX, S_XX_W, S_SQRT, S_POW, S_POW_W, S_SEED, S_SEED_W,
    S_RX, S_RX_W, S_RK, S_RK_W, S_RP, S_RP_W, S_DIV, S_DIV_W,
    S_FIN, S_NSC, S_NSC_W, S_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [31:0] b;
    logic [4:0]  sh;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
    logic [4:0]  d;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
    logic        sat;
  } unit_rsp_t;

  // (2m-1)!! for m = 0..MAX_DEGREE
  function automatic logic [63:0] dfact(input logic [3:0] am);
    logic [63:0] f;
    case (am)
      4'd0:    f = 64'd1;
      4'd1:    f = 64'd1;
      4'd2:    f = 64'd3;
      4'd3:    f = 64'd15;
      4'd4:    f = 64'd105;
      4'd5:    f = 64'd945;
      4'd6:    f = 64'd10395;
      4'd7:    f = 64'd135135;
      4'd8:    f = 64'd2027025;
      4'd9:    f = 64'd34459425;
      4'd10:   f = 64'd654729075;
      4'd11:   f = 64'd13749310575;
      4'd12:   f = 64'd316234143225;
      default: f = 64'd1;
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/alg_mul.sv =====
// Shared rounding multiplier: |a| x |b| in two 32x32 partial products, then
// round half away from zero, shift and saturate. Depends on alg_pkg.
`timescale 1ns / 1ps

module alg_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  alg_pkg::mul_req_t req,
  output alg_pkg::unit_rsp_t rsp
);

  logic [63:0] ua_r;
  logic [31:0] ub_r;
  logic        neg_r;
  logic [4:0]  sh_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [63:0] plo_r, phi_r;
  logic [63:0] res_r, res_nxt;
  logic        sat_r, sat_nxt;
  logic        done_r;

  logic [95:0] prod, rnd, shd;
  logic [62:0] mag;

  always_comb begin
    rnd  = (96'd1 << sh_r) >> 1;
    prod = {phi_r, 32'd0} + {32'd0, plo_r} + rnd;
    shd  = prod >> sh_r;
    mag  = shd[62:0];
    sat_nxt = |shd[95:63];
    if (sat_nxt) begin
      res_nxt = neg_r ? alg_pkg::VAL_MIN : alg_pkg::VAL_MAX;
    end else if (neg_r) begin
      res_nxt = 64'd0 - {1'b0, mag};
    end else begin
      res_nxt = {1'b0, mag};
    end
    phase_nxt = phase_r;
    if (req.start) begin
      phase_nxt = 2'd1;
    end else if (phase_r != 2'd0) begin
      phase_nxt = 2'(phase_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      done_r  <= (phase_r == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua_r  <= req.a[63] ? (64'd0 - req.a) : req.a;
      ub_r  <= req.b[31] ? (32'd0 - req.b) : req.b;
      neg_r <= req.a[63] ^ req.b[31];
      sh_r  <= req.sh;
    end
    if (phase_r == 2'd1) begin
      plo_r <= ua_r[31:0] * ub_r;
    end
    if (phase_r == 2'd2) begin
      phi_r <= ua_r[63:32] * ub_r;
    end
    if (phase_r == 2'd3) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.sat  = sat_r;

endmodule

// ===== hdl/alg_div.sv =====
// Rounded divider by a small integer, four quotient bits per cycle.
// Rounds half away from zero and saturates. Depends on alg_pkg.
`timescale 1ns / 1ps

module alg_div (
  input  logic              clk,
  input  logic              rst_n,
  input  alg_pkg::div_req_t req,
  output alg_pkg::unit_rsp_t rsp
);

  logic [63:0] num_r, num_nxt;
  logic [4:0]  rem_r, rem_nxt;
  logic [4:0]  d_r;
  logic        neg_r;
  logic [3:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [63:0] res_r, res_nxt;
  logic        sat_r;

  logic [5:0]  tmp;
  logic        qb;

  always_comb begin
    num_nxt = num_r;
    rem_nxt = rem_r;
    for (int j = 0; j < 4; j++) begin
      tmp = {rem_nxt, num_nxt[63]};
      qb  = (tmp >= {1'b0, d_r});
      rem_nxt = qb ? 5'(tmp - {1'b0, d_r}) : tmp[4:0];
      num_nxt = {num_nxt[62:0], qb};
    end
    if (num_nxt[63]) begin
      res_nxt = neg_r ? alg_pkg::VAL_MIN : alg_pkg::VAL_MAX;
    end else if (neg_r) begin
      res_nxt = 64'd0 - num_nxt;
    end else begin
      res_nxt = num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 4'd0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd0;
      end else if (busy_r) begin
        cnt_r <= 4'(cnt_r + 4'd1);
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= (req.n[63] ? (64'd0 - req.n) : req.n) + {60'd0, req.d[4:1]};
      rem_r <= 5'd0;
      d_r   <= req.d;
      neg_r <= req.n[63];
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
      if (cnt_r == 4'd15) begin
        res_r <= res_nxt;
        sat_r <= num_nxt[63];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;
  assign rsp.sat  = sat_r;

endmodule

// ===== hdl/assoc_legendre_evaluator_core.sv =====
// An order or range error goes straight to the output stage. Any other item runs
//   x*x, the 32-step square root, the power and seed products, the recurrence for
//   l>|m| and the negative-m divisions, on the shared multiplier and the divider.
// Flow: a new item is accepted only in idle, after the last result has been loaded into
//   the output register; a stalled output holds a finished result, delaying the next item.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops out_tvalid.
// Depends on alg_pkg, alg_mul, alg_div and the assertion macro header.
`timescale 1ns / 1ps
`include "assoc_legendre_evaluator_core_macros.svh"

module assoc_legendre_evaluator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [alg_pkg::IN_TDATA_W-1:0] in_tdata,   // degree[3:0], order[8:4], argument[40:9], zero pad
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [alg_pkg::OUT_TDATA_W-1:0] out_tdata  // value[63:0], status[65:64], zero pad
);

  alg_pkg::state_t  state_r, state_nxt;
  logic [3:0]  l_r, l_nxt;
  logic [3:0]  am_r, am_nxt;
  logic        mneg_r, mneg_nxt;
  logic [31:0] x_r, x_nxt;
  logic [31:0] s_r, s_nxt;
  logic [31:0] t_r, t_nxt;
  logic [63:0] cur_r, cur_nxt;
  logic [63:0] prev_r, prev_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [4:0]  sq_i_r, sq_i_nxt;
  logic [63:0] v_r, v_nxt;
  logic [63:0] r_r, r_nxt;
  logic        sat_r, sat_nxt;
  alg_pkg::status_t err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_value_r, out_value_nxt;
  alg_pkg::status_t out_status_r, out_status_nxt;

  alg_pkg::mul_req_t  mul_req;
  alg_pkg::div_req_t  div_req;
  alg_pkg::unit_rsp_t mul_rsp, div_rsp;

  logic [3:0]  deg_in, l_in;
  logic [4:0]  ord_in, am_in;
  logic [31:0] arg_in;
  logic [63:0] sq_bit, sq_sum;
  logic [63:0] diff;
  logic        sub_ovf;
  logic [4:0]  k_inc;
  logic        load;

  alg_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));
  alg_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alg_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r          <= l_nxt;
    am_r         <= am_nxt;
    mneg_r       <= mneg_nxt;
    x_r          <= x_nxt;
    s_r          <= s_nxt;
    t_r          <= t_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    acc_r        <= acc_nxt;
    k_r          <= k_nxt;
    cnt_r        <= cnt_nxt;
    sq_i_r       <= sq_i_nxt;
    v_r          <= v_nxt;
    r_r          <= r_nxt;
    sat_r        <= sat_nxt;
    err_r        <= err_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    deg_in = in_tdata[3:0];
    ord_in = in_tdata[8:4];
    arg_in = in_tdata[40:9];
    l_in   = (deg_in > 4'(alg_pkg::MAX_DEGREE)) ? 4'(alg_pkg::MAX_DEGREE) : deg_in;
    am_in  = ord_in[4] ? (5'd0 - ord_in) : ord_in;

    sq_bit = 64'd1 << {sq_i_r, 1'b0};
    sq_sum = r_r + sq_bit;

    // saturating acc - prev (prev holds the (k+m) P_{k-1} term here)
    diff    = acc_r - prev_r;
    sub_ovf = (acc_r[63] != prev_r[63]) && (diff[63] != acc_r[63]);

    k_inc = 5'(k_r + 5'd1);
    load  = 1'b0;

    state_nxt      = state_r;
    l_nxt          = l_r;
    am_nxt         = am_r;
    mneg_nxt       = mneg_r;
    x_nxt          = x_r;
    s_nxt          = s_r;
    t_nxt          = t_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    acc_nxt        = acc_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    sq_i_nxt       = sq_i_r;
    v_nxt          = v_r;
    r_nxt          = r_r;
    sat_nxt        = sat_r;
    err_nxt        = err_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    mul_req = '0;
    div_req = '0;

    case (state_r)
      alg_pkg::S_IDLE: begin
        if (in_tvalid) begin
          l_nxt    = l_in;
          am_nxt   = am_in[3:0];
          mneg_nxt = ord_in[4];
          x_nxt    = arg_in;
          sat_nxt  = 1'b0;
          cur_nxt  = 64'd0;
          if (am_in > {1'b0, l_in}) begin
            err_nxt   = alg_pkg::ST_ORDER;
            state_nxt = alg_pkg::S_DONE;
          end else if ((!arg_in[31] && arg_in > alg_pkg::ARG_ONE32) ||
                       (arg_in[31] && arg_in < alg_pkg::ARG_MONE32)) begin
            err_nxt   = alg_pkg::ST_RANGE;
            state_nxt = alg_pkg::S_DONE;
          end else begin
            err_nxt   = alg_pkg::ST_OK;
            state_nxt = alg_pkg::S_XX;
          end
        end
      end
      alg_pkg::S_XX: begin
        mul_req.start = 1'b1;
        mul_req.a     = {{32{x_r[31]}}, x_r};
        mul_req.b     = x_r;
        mul_req.sh    = 5'd0;
        state_nxt     = alg_pkg::S_XX_W;
      end
      alg_pkg::S_XX_W: begin
        if (mul_rsp.done) begin
          v_nxt     = alg_pkg::SQ_ONE - mul_rsp.res;
          r_nxt     = 64'd0;
          sq_i_nxt  = 5'd31;
          state_nxt = alg_pkg::S_SQRT;
        end
      end
      alg_pkg::S_SQRT: begin
        // one result bit per cycle, top bit pair first
        if (v_r >= sq_sum) begin
          v_nxt = v_r - sq_sum;
          r_nxt = (r_r >> 1) + sq_bit;
        end else begin
          r_nxt = r_r >> 1;
        end
        sq_i_nxt = 5'(sq_i_r - 5'd1);
        if (sq_i_r == 5'd0) begin
          s_nxt     = r_nxt[31:0];
          t_nxt     = alg_pkg::ARG_ONE32;
          cnt_nxt   = 4'd0;
          state_nxt = alg_pkg::S_POW;
        end
      end
      alg_pkg::S_POW: begin
        if (cnt_r == am_r) begin
          state_nxt = alg_pkg::S_SEED;
        end else begin
          mul_req.start = 1'b1;
          mul_req.a     = {32'd0, t_r};
          mul_req.b     = s_r;
          mul_req.sh    = 5'(alg_pkg::ARG_FRAC_BITS);
          state_nxt     = alg_pkg::S_POW_W;
        end
      end
      alg_pkg::S_POW_W: begin
        if (mul_rsp.done) begin
          t_nxt     = mul_rsp.res[31:0];
          cnt_nxt   = 4'(cnt_r + 4'd1);
          state_nxt = alg_pkg::S_POW;
        end
      end
      alg_pkg::S_SEED: begin
        mul_req.start = 1'b1;
        mul_req.a     = alg_pkg::dfact(am_r);
        mul_req.b     = t_r;
        mul_req.sh    = 5'(alg_pkg::SEED_SH);
        state_nxt     = alg_pkg::S_SEED_W;
      end
      alg_pkg::S_SEED_W: begin
        if (mul_rsp.done) begin
          cur_nxt   = am_r[0] ? (64'd0 - mul_rsp.res) : mul_rsp.res;
          sat_nxt   = sat_r | mul_rsp.sat;
          k_nxt     = {1'b0, am_r};
          state_nxt = (am_r < l_r) ? alg_pkg::S_RX : alg_pkg::S_FIN;
        end
      end
      alg_pkg::S_RX: begin
        mul_req.start = 1'b1;
        mul_req.a     = cur_r;
        mul_req.b     = x_r;
        mul_req.sh    = 5'(alg_pkg::ARG_FRAC_BITS);
        state_nxt     = alg_pkg::S_RX_W;
      end
      alg_pkg::S_RX_W: begin
        if (mul_rsp.done) begin
          acc_nxt   = mul_rsp.res;
          sat_nxt   = sat_r | mul_rsp.sat;
          state_nxt = alg_pkg::S_RK;
        end
      end
      alg_pkg::S_RK: begin
        mul_req.start = 1'b1;
        mul_req.a     = acc_r;
        mul_req.b     = {26'd0, k_r, 1'b1};
        mul_req.sh    = 5'd0;
        state_nxt     = alg_pkg::S_RK_W;
      end
      alg_pkg::S_RK_W: begin
        if (mul_rsp.done) begin
          acc_nxt = mul_rsp.res;
          sat_nxt = sat_r | mul_rsp.sat;
          if (k_r == {1'b0, am_r}) begin
            // first step: P_{m+1}^m = (2m+1) x P_m^m
            prev_nxt  = cur_r;
            cur_nxt   = mul_rsp.res;
            k_nxt     = k_inc;
            state_nxt = (k_inc < {1'b0, l_r}) ? alg_pkg::S_RX : alg_pkg::S_FIN;
          end else begin
            state_nxt = alg_pkg::S_RP;
          end
        end
      end
      alg_pkg::S_RP: begin
        mul_req.start = 1'b1;
        mul_req.a     = prev_r;
        mul_req.b     = {27'd0, 5'(k_r + {1'b0, am_r})};
        mul_req.sh    = 5'd0;
        state_nxt     = alg_pkg::S_RP_W;
      end
      alg_pkg::S_RP_W: begin
        if (mul_rsp.done) begin
          prev_nxt  = mul_rsp.res;
          sat_nxt   = sat_r | mul_rsp.sat;
          state_nxt = alg_pkg::S_DIV;
        end
      end
      alg_pkg::S_DIV: begin
        div_req.start = 1'b1;
        div_req.n     = sub_ovf ? (prev_r[63] ? alg_pkg::VAL_MAX : alg_pkg::VAL_MIN) : diff;
        div_req.d     = 5'(k_r - {1'b0, am_r} + 5'd1);
        sat_nxt       = sat_r | sub_ovf;
        state_nxt     = alg_pkg::S_DIV_W;
      end
      alg_pkg::S_DIV_W: begin
        if (div_rsp.done) begin
          prev_nxt  = cur_r;
          cur_nxt   = div_rsp.res;
          sat_nxt   = sat_r | div_rsp.sat;
          k_nxt     = k_inc;
          state_nxt = (k_inc < {1'b0, l_r}) ? alg_pkg::S_RX : alg_pkg::S_FIN;
        end
      end
      alg_pkg::S_FIN: begin
        if (mneg_r) begin
          k_nxt     = 5'({1'b0, l_r} - {1'b0, am_r} + 5'd1);
          state_nxt = alg_pkg::S_NSC;
        end else begin
          state_nxt = alg_pkg::S_DONE;
        end
      end
      alg_pkg::S_NSC: begin
        // negative order: divide by (l-m+1) .. (l+m), then apply the sign
        if (k_r > 5'({1'b0, l_r} + {1'b0, am_r})) begin
          if (am_r[0]) begin
            cur_nxt = 64'd0 - cur_r;
          end
          state_nxt = alg_pkg::S_DONE;
        end else begin
          div_req.start = 1'b1;
          div_req.n     = cur_r;
          div_req.d     = k_r;
          state_nxt     = alg_pkg::S_NSC_W;
        end
      end
      alg_pkg::S_NSC_W: begin
        if (div_rsp.done) begin
          cur_nxt   = div_rsp.res;
          sat_nxt   = sat_r | div_rsp.sat;
          k_nxt     = k_inc;
          state_nxt = alg_pkg::S_NSC;
        end
      end
      alg_pkg::S_DONE: begin
        if (!out_valid_r || out_tready) begin
          load          = 1'b1;
          out_value_nxt = cur_r;
          if (err_r != alg_pkg::ST_OK) begin
            out_status_nxt = err_r;
          end else if (sat_r) begin
            out_status_nxt = alg_pkg::ST_SAT;
          end else begin
            out_status_nxt = alg_pkg::ST_OK;
          end
          state_nxt = alg_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = alg_pkg::S_IDLE;
      end
    endcase

    out_valid_nxt = load | (out_valid_r & ~out_tready);
  end

  assign in_tready  = (state_r == alg_pkg::S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r, out_value_r};

  `ALG_ASSERT_NEXT(a_done_loads, clk, rst_n,
    (state_r == alg_pkg::S_DONE) && (!out_valid_r || out_tready), out_valid_r)
  `ALG_ASSERT_IMPL(a_err_zero, clk, rst_n,
    out_valid_r && (out_status_r == alg_pkg::ST_ORDER || out_status_r == alg_pkg::ST_RANGE),
    out_value_r == 64'd0)
  `ALG_ASSERT_IMPL(a_mul_owner, clk, rst_n, mul_rsp.done,
    state_r == alg_pkg::S_XX_W || state_r == alg_pkg::S_POW_W ||
    state_r == alg_pkg::S_SEED_W || state_r == alg_pkg::S_RX_W ||
    state_r == alg_pkg::S_RK_W || state_r == alg_pkg::S_RP_W)
  `ALG_ASSERT_IMPL(a_div_owner, clk, rst_n, div_rsp.done,
    state_r == alg_pkg::S_DIV_W || state_r == alg_pkg::S_NSC_W)

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for assoc_legendre_evaluator_core: directed and random items,
// bursty input, stalling output, compared against a bit-exact fixed-point predictor.
// Depends on alg_pkg and the RTL of the evaluator.
`timescale 1ns / 1ps

class legendre_scoreboard;
  typedef struct {
    logic [63:0]      value;
    alg_pkg::status_t status;
  } legendre_result_t;

  legendre_result_t awaited[$];
  int               mismatches;
  bit               sat_seen;

  function logic [63:0] magnitude(longint v);
    logic [63:0] u;
    u = v;
    if (v < 0) u = 64'd0 - u;
    return u;
  endfunction

  // signed value from a magnitude, clipped to the 64-bit range
  function longint fold(bit neg, logic [127:0] mag);
    logic [63:0] m64;
    m64 = mag[63:0];
    if (mag >= (128'd1 << 63)) begin
      sat_seen = 1;
      return neg ? alg_pkg::VAL_MIN : alg_pkg::VAL_MAX;
    end
    return neg ? -longint'(m64) : longint'(m64);
  endfunction

  // round(a * b / 2^sh), half away from zero; only the low 32 bits of |b| count
  function longint scaled_product(longint a, longint b, int sh);
    bit           neg;
    logic [127:0] p;
    logic [63:0]  ub;
    neg = (a < 0) != (b < 0);
    ub = magnitude(b) & 64'hFFFF_FFFF;
    p = {64'd0, magnitude(a)} * {64'd0, ub};
    if (sh > 0) p = p + (128'd1 << (sh - 1));
    return fold(neg, p >> sh);
  endfunction

  function longint rounded_quotient(longint n, logic [63:0] d);
    logic [63:0] q;
    q = (magnitude(n) + d / 2) / d;
    return fold(n < 0, {64'd0, q});
  endfunction

  function longint clipped_diff(longint a, longint b);
    if (b > 0 && a < longint'(alg_pkg::VAL_MIN) + b) begin
      sat_seen = 1;
      return alg_pkg::VAL_MIN;
    end
    if (b < 0 && a > longint'(alg_pkg::VAL_MAX) + b) begin
      sat_seen = 1;
      return alg_pkg::VAL_MAX;
    end
    return a - b;
  endfunction

  function logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] r, bit_pos;
    r = 0;
    bit_pos = 64'd1 << 62;
    while (bit_pos > v) bit_pos = bit_pos >> 2;
    while (bit_pos != 0) begin
      if (v >= r + bit_pos) begin
        v = v - (r + bit_pos);
        r = (r >> 1) + bit_pos;
      end else begin
        r = r >> 1;
      end
      bit_pos = bit_pos >> 2;
    end
    return r;
  endfunction

  function legendre_result_t legendre_value(logic [3:0] deg, logic [4:0] ord,
                                            logic [31:0] arg);
    legendre_result_t res;
    longint           l, m, am, x, one, cur, prev, nx, ta, tb;
    logic [63:0]      sq, s, t, df;
    sat_seen = 0;
    l = deg;
    m = longint'(signed'(ord));
    x = longint'(signed'(arg));
    one = longint'(1) << alg_pkg::ARG_FRAC_BITS;
    if (l > alg_pkg::MAX_DEGREE) l = alg_pkg::MAX_DEGREE;
    am = m < 0 ? -m : m;
    res.value = 0;
    if (am > l) begin
      res.status = alg_pkg::ST_ORDER;
      return res;
    end
    if (x > one || x < -one) begin
      res.status = alg_pkg::ST_RANGE;
      return res;
    end
    // seed: (-1)^am (2am-1)!! s^am
    sq = alg_pkg::SQ_ONE - 64'(x * x);
    s = floor_sqrt(sq);
    t = one;
    for (int k = 0; k < am; k++)
      t = (t * s + (64'd1 << (alg_pkg::ARG_FRAC_BITS - 1))) >> alg_pkg::ARG_FRAC_BITS;
    df = 1;
    for (longint k = 2 * am - 1; k > 0; k -= 2) df = df * k;
    cur = scaled_product(longint'(df), longint'(t), alg_pkg::SEED_SH);
    if (am[0]) cur = -cur;
    if (l > am) begin
      prev = cur;
      cur = scaled_product(scaled_product(cur, x, alg_pkg::ARG_FRAC_BITS), 2 * am + 1, 0);
      for (longint k = am + 1; k < l; k++) begin
        ta = scaled_product(scaled_product(cur, x, alg_pkg::ARG_FRAC_BITS), 2 * k + 1, 0);
        tb = scaled_product(prev, k + am, 0);
        nx = rounded_quotient(clipped_diff(ta, tb), 64'(k - am + 1));
        prev = cur;
        cur = nx;
      end
    end
    if (m < 0) begin
      for (longint k = l - am + 1; k <= l + am; k++) cur = rounded_quotient(cur, 64'(k));
      if (am[0]) cur = -cur;
    end
    res.value = cur;
    res.status = sat_seen ? alg_pkg::ST_SAT : alg_pkg::ST_OK;
    return res;
  endfunction

  function void note_item(logic [47:0] data);
    awaited.push_back(legendre_value(data[3:0], data[8:4], data[40:9]));
  endfunction

  function void check_result(logic [71:0] data);
    legendre_result_t e;
    if (awaited.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result: value %h status %0d",
                                     data[63:0], data[65:64]);
      return;
    end
    e = awaited.pop_front();
    if (data[63:0] !== e.value || data[65:64] !== e.status || data[71:66] !== 6'd0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch: expected value %h status %0d, got value %h status %0d pad %h",
                 e.value, e.status, data[63:0], data[65:64], data[71:66]);
    end
  endfunction
endclass

module testbench;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  legendre_scoreboard results = new();
  int burst_left;
  int cycle_count = 0;

  assoc_legendre_evaluator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) results.note_item(in_tdata);
    if (rst_n && out_tvalid && out_tready) results.check_result(out_tdata);
  end

  // receiver: alternating stretches of always-ready and random stalls
  always @(negedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n !== 1'b1) out_tready <= 1'b0;
    else if ((cycle_count / 400) % 3 == 0) out_tready <= 1'b1;
    else if ((cycle_count / 400) % 3 == 1) out_tready <= ($urandom_range(0, 3) != 0);
    else out_tready <= ($urandom_range(0, 1) != 0);
  end

  task automatic send_item(logic [3:0] deg, logic [4:0] ord, logic [31:0] arg);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid = 1'b1;
    in_tdata = {7'd0, arg, ord, deg};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    in_tvalid = 1'b0;
    burst_left--;
  endtask

  task automatic send_random_item();
    logic [3:0]  deg;
    logic [4:0]  ord;
    logic [31:0] arg;
    int          ad;
    deg = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 12));
    ad = deg > alg_pkg::MAX_DEGREE ? alg_pkg::MAX_DEGREE : deg;
    if ($urandom_range(0, 9) == 0) ord = 5'($urandom);
    else ord = 5'($urandom_range(0, ad));
    if ($urandom_range(0, 1) == 1 && ord != 0) ord = 5'(0) - ord;
    case ($urandom_range(0, 9))
      0:       arg = $urandom;
      1:       arg = $urandom_range(0, 1) ? alg_pkg::ARG_ONE32 : alg_pkg::ARG_MONE32;
      default: arg = $urandom_range(32'h8000_0000, 0) - 32'h4000_0000;
    endcase
    send_item(deg, ord, arg);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    burst_left = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    send_item(4'd0, 5'd0, 32'd0);
    send_item(4'd12, 5'd12, 32'd0);
    send_item(4'd12, 5'(-12), 32'd0);
    send_item(4'd12, 5'd0, alg_pkg::ARG_ONE32);
    send_item(4'd12, 5'd0, alg_pkg::ARG_MONE32);
    send_item(4'd15, 5'd3, 32'h2000_0000);        // degree clamped
    send_item(4'd13, 5'(-13), 32'h1000_0000);     // clamped degree still below |m|
    send_item(4'd3, 5'd5, 32'd0);                 // order above degree
    send_item(4'd3, 5'(-5), 32'd0);
    send_item(4'd0, 5'd15, 32'd0);
    send_item(4'd15, 5'(-16), 32'd0);
    send_item(4'd5, 5'd2, alg_pkg::ARG_ONE32 + 32'd1);     // just out of range
    send_item(4'd5, 5'd2, alg_pkg::ARG_MONE32 - 32'd1);
    send_item(4'd5, 5'd2, 32'h7FFF_FFFF);
    send_item(4'd5, 5'd2, 32'h8000_0000);
    send_item(4'd3, 5'd1, alg_pkg::ARG_ONE32);             // s = 0
    send_item(4'd7, 5'(-3), 32'hE000_0000);
    send_item(4'd12, 5'd1, 32'h0000_0001);
    send_item(4'd11, 5'(-11), 32'hC000_0001);
    send_item(4'd1, 5'(-1), 32'h3000_0000);
    send_item(4'd12, 5'd6, 32'h2D41_3CCD);

    for (int i = 0; i < 830; i++) send_random_item();

    while (results.awaited.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (results.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
